// ----- rtl/interface_adapter_timers_irq_defines.svh -----
// Assertion macros for the interface adapter top-level RTL.
`ifndef INTERFACE_ADAPTER_TIMERS_IRQ_DEFINES_SVH
`define INTERFACE_ADAPTER_TIMERS_IRQ_DEFINES_SVH

`ifndef SYNTH
`define IAT_ASSERT_CLK(lbl, ck, rn, prop) \
	lbl: assert property (@(posedge ck) disable iff (!rn) prop) \
		else $error("interface adapter assertion failed");
`define IAT_ASSERT(lbl, prop) `IAT_ASSERT_CLK(lbl, clk, arst_n, prop)
`else
`define IAT_ASSERT_CLK(lbl, ck, rn, prop)
`define IAT_ASSERT(lbl, prop)
`endif

`endif

// ----- rtl/iat_pkg.sv -----
// Types and constants shared by the interface adapter modules.
package iat_pkg;

	// Request commands.
	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_WRITE = 2'd2;

	// Register map.
	localparam logic [3:0] REG_ORB    = 4'd0;
	localparam logic [3:0] REG_ORA    = 4'd1;
	localparam logic [3:0] REG_DDRB   = 4'd2;
	localparam logic [3:0] REG_DDRA   = 4'd3;
	localparam logic [3:0] REG_T1CL   = 4'd4;
	localparam logic [3:0] REG_T1CH   = 4'd5;
	localparam logic [3:0] REG_T1LL   = 4'd6;
	localparam logic [3:0] REG_T1LH   = 4'd7;
	localparam logic [3:0] REG_T2CL   = 4'd8;
	localparam logic [3:0] REG_T2CH   = 4'd9;
	localparam logic [3:0] REG_SR     = 4'd10;
	localparam logic [3:0] REG_ACR    = 4'd11;
	localparam logic [3:0] REG_PCR    = 4'd12;
	localparam logic [3:0] REG_IFR    = 4'd13;
	localparam logic [3:0] REG_IER    = 4'd14;
	localparam logic [3:0] REG_ORA_NH = 4'd15;

	// Interrupt flag and auxiliary control bit positions.
	localparam int IRQ_T1_BIT   = 6;
	localparam int IRQ_T2_BIT   = 5;
	localparam int AUX_T1_FREE  = 6;
	localparam int AUX_T2_PULSE = 5;
	localparam int IER_SET_BIT  = 7;

	typedef struct packed {
		logic [1:0] command;
		logic [3:0] reg_index;
		logic [7:0] write_data;
		logic       device_select;
		logic       no_side_effect;
		logic [7:0] port_a_pins;
		logic [7:0] port_b_pins;
	} in_item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       irq;
		logic [7:0] port_a_drive;
		logic [7:0] port_b_drive;
	} out_item_t;

	// Control from the register block to the timers.
	typedef struct packed {
		logic       tick;
		logic       wr_en;
		logic [3:0] idx;
		logic [7:0] wdata;
		logic       t1_free;
		logic       t2_pulse;
	} tmr_ctl_t;

	// Timer status back to the register block.
	typedef struct packed {
		logic [15:0] t1_count;
		logic [15:0] t1_latch;
		logic [15:0] t2_count;
		logic [15:0] t2_latch;
		logic        t1_set;
		logic        t2_set;
	} tmr_stat_t;

endpackage

// ----- rtl/iat_if.sv -----
// Valid/ready request channels for the interface adapter.
interface iat_in_if;
	logic             valid;
	logic             ready;
	iat_pkg::in_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface iat_out_if;
	logic              valid;
	logic              ready;
	iat_pkg::out_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ----- rtl/iat_timers.sv -----
// Two 16-bit down-counters with reload latches and phase control.
module iat_timers (
	input  logic              clk,
	input  logic              arst_n,
	input  iat_pkg::tmr_ctl_t  ctl,
	output iat_pkg::tmr_stat_t stat
);

	typedef enum logic [1:0] {
		PH_INACTIVE = 2'd0,
		PH_LOAD     = 2'd1,
		PH_ACTIVE   = 2'd2
	} phase_t;

	logic [15:0] t1_latch_q, t1_count_q, t2_latch_q, t2_count_q;
	phase_t      t1_phase_q, t2_phase_q;
	logic        t1_wrapped_q;

	// A wrap happens when a counting timer steps from zero.
	logic t1_wrap, t2_wrap;
	assign t1_wrap = (t1_phase_q != PH_LOAD) && (t1_count_q == '0);
	assign t2_wrap = (t2_phase_q != PH_LOAD) && (t2_count_q == '0);

	assign stat.t1_count = t1_count_q;
	assign stat.t1_latch = t1_latch_q;
	assign stat.t2_count = t2_count_q;
	assign stat.t2_latch = t2_latch_q;
	assign stat.t1_set   = ctl.tick && t1_wrap && (t1_phase_q == PH_ACTIVE);
	assign stat.t2_set   = ctl.tick && t2_wrap && (t2_phase_q == PH_ACTIVE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t1_latch_q   <= '0;
			t1_count_q   <= '0;
			t2_latch_q   <= '0;
			t2_count_q   <= '0;
			t1_phase_q   <= PH_INACTIVE;
			t2_phase_q   <= PH_INACTIVE;
			t1_wrapped_q <= 1'b0;
		end else if (ctl.tick) begin
			case (t1_phase_q)
				PH_LOAD: begin
					t1_count_q   <= t1_latch_q;
					t1_phase_q   <= (t1_wrapped_q && !ctl.t1_free) ? PH_INACTIVE : PH_ACTIVE;
					t1_wrapped_q <= 1'b0;
				end
				default: begin
					t1_count_q <= t1_count_q - 16'd1;
					if (t1_wrap) begin
						t1_wrapped_q <= 1'b1;
						t1_phase_q   <= PH_LOAD;
					end
				end
			endcase
			case (t2_phase_q)
				PH_LOAD: begin
					t2_count_q <= t2_latch_q;
					t2_phase_q <= PH_ACTIVE;
				end
				default: begin
					t2_count_q <= t2_count_q - 16'd1;
					if (t2_wrap) begin
						t2_phase_q <= ctl.t2_pulse ? PH_ACTIVE : PH_INACTIVE;
					end
				end
			endcase
		end else if (ctl.wr_en) begin
			case (ctl.idx)
				iat_pkg::REG_T1CL, iat_pkg::REG_T1LL: begin
					t1_latch_q[7:0] <= ctl.wdata;
				end
				iat_pkg::REG_T1CH: begin
					t1_latch_q[15:8] <= ctl.wdata;
					t1_phase_q       <= PH_LOAD;
					t1_wrapped_q     <= 1'b0;
				end
				iat_pkg::REG_T1LH: begin
					t1_latch_q[15:8] <= ctl.wdata;
				end
				iat_pkg::REG_T2CL: begin
					t2_latch_q[7:0] <= ctl.wdata;
				end
				iat_pkg::REG_T2CH: begin
					t2_latch_q[15:8] <= ctl.wdata;
					t2_phase_q       <= PH_LOAD;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ----- rtl/interface_adapter_timers_irq.sv -----
// Flow: a request accepted from the source is held in the processing stage, then moves
// into the output register when it advances and is offered to the sink from there.
// Throughput: one request per cycle while the sink keeps taking results; the register
// file and timers update in the single processing stage, ahead of the output register.
// Reset: arst_n clears the register file, timers, flags and both channel valid bits.
// Ready stays high while the output register is empty or being taken.
`include "interface_adapter_timers_irq_defines.svh"

module interface_adapter_timers_irq (
	input  logic       clk,
	input  logic       arst_n,
	iat_in_if.sink     in_ch,
	iat_out_if.source  out_ch
);

	iat_pkg::in_item_t  item_s1;
	logic               valid_s1;
	iat_pkg::out_item_t out_q;
	logic               out_valid_q;

	logic advance, is_tick, is_rd, is_wr;

	logic [7:0] dir_a_q, dir_b_q, out_a_q, out_b_q, in_a_q, in_b_q, aux_q;
	logic [6:0] ien_q, flags_q;
	logic [7:0] dir_a_n, dir_b_n, out_a_n, out_b_n, in_a_n, in_b_n, aux_n;
	logic [6:0] ien_n, flags_n, flags_clr, flags_set;
	logic [7:0] rd;
	iat_pkg::out_item_t result;

	iat_pkg::tmr_ctl_t  tctl;
	iat_pkg::tmr_stat_t tstat;

	assign advance     = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;
	assign is_tick = advance && (item_s1.command == iat_pkg::CMD_TICK);
	assign is_rd   = advance && item_s1.device_select && (item_s1.command == iat_pkg::CMD_READ);
	assign is_wr   = advance && item_s1.device_select && (item_s1.command == iat_pkg::CMD_WRITE);

	assign tctl.tick     = is_tick;
	assign tctl.wr_en    = is_wr;
	assign tctl.idx      = item_s1.reg_index;
	assign tctl.wdata    = item_s1.write_data;
	assign tctl.t1_free  = aux_q[iat_pkg::AUX_T1_FREE];
	assign tctl.t2_pulse = aux_q[iat_pkg::AUX_T2_PULSE];

	iat_timers u_timers (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (tctl),
		.stat   (tstat)
	);

	always_comb begin
		dir_a_n   = dir_a_q;
		dir_b_n   = dir_b_q;
		out_a_n   = out_a_q;
		out_b_n   = out_b_q;
		in_a_n    = in_a_q;
		in_b_n    = in_b_q;
		aux_n     = aux_q;
		ien_n     = ien_q;
		flags_clr = '0;
		flags_set = '0;
		rd        = '0;
		flags_set[iat_pkg::IRQ_T1_BIT] = tstat.t1_set;
		flags_set[iat_pkg::IRQ_T2_BIT] = tstat.t2_set;

		// Pins are latched only on bits that the direction mask leaves as inputs.
		if (is_tick) begin
			in_a_n = (in_a_q & dir_a_q) | (item_s1.port_a_pins & ~dir_a_q);
			in_b_n = (in_b_q & dir_b_q) | (item_s1.port_b_pins & ~dir_b_q);
		end

		if (is_rd) begin
			case (item_s1.reg_index)
				iat_pkg::REG_ORB: rd = (out_b_q & dir_b_q) | (in_b_q & ~dir_b_q);
				iat_pkg::REG_ORA, iat_pkg::REG_ORA_NH: rd = in_a_q;
				iat_pkg::REG_DDRB: rd = dir_b_q;
				iat_pkg::REG_DDRA: rd = dir_a_q;
				iat_pkg::REG_T1CL: begin
					rd = tstat.t1_count[7:0];
					flags_clr[iat_pkg::IRQ_T1_BIT] = !item_s1.no_side_effect;
				end
				iat_pkg::REG_T1CH: rd = tstat.t1_count[15:8];
				iat_pkg::REG_T1LL: rd = tstat.t1_latch[7:0];
				iat_pkg::REG_T1LH: rd = tstat.t1_latch[15:8];
				iat_pkg::REG_T2CL: begin
					rd = tstat.t2_count[7:0];
					flags_clr[iat_pkg::IRQ_T2_BIT] = !item_s1.no_side_effect;
				end
				iat_pkg::REG_T2CH: rd = tstat.t2_count[15:8];
				iat_pkg::REG_ACR: rd = aux_q;
				iat_pkg::REG_IFR: rd = {|(ien_q & flags_q), flags_q};
				iat_pkg::REG_IER: rd = {1'b1, ien_q};
				default: rd = '0;
			endcase
		end

		if (is_wr) begin
			case (item_s1.reg_index)
				iat_pkg::REG_ORB: out_b_n = item_s1.write_data;
				iat_pkg::REG_ORA, iat_pkg::REG_ORA_NH: out_a_n = item_s1.write_data;
				iat_pkg::REG_DDRB: dir_b_n = item_s1.write_data;
				iat_pkg::REG_DDRA: dir_a_n = item_s1.write_data;
				iat_pkg::REG_T1CH, iat_pkg::REG_T1LH: flags_clr[iat_pkg::IRQ_T1_BIT] = 1'b1;
				iat_pkg::REG_T2CH: flags_clr[iat_pkg::IRQ_T2_BIT] = 1'b1;
				iat_pkg::REG_ACR: aux_n = item_s1.write_data;
				iat_pkg::REG_IFR: flags_clr = item_s1.write_data[6:0];
				iat_pkg::REG_IER: begin
					if (item_s1.write_data[iat_pkg::IER_SET_BIT]) begin
						ien_n = ien_q | item_s1.write_data[6:0];
					end else begin
						ien_n = ien_q & ~item_s1.write_data[6:0];
					end
				end
				default: begin
				end
			endcase
		end

		flags_n = (flags_q & ~flags_clr) | flags_set;

		result.read_data    = rd;
		result.irq          = |(ien_n & flags_n);
		result.port_a_drive = (out_a_n & dir_a_n) | (in_a_n & ~dir_a_n);
		result.port_b_drive = (out_b_n & dir_b_n) | (in_b_n & ~dir_b_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_a_q <= '0;
			dir_b_q <= '0;
			out_a_q <= '0;
			out_b_q <= '0;
			in_a_q  <= '0;
			in_b_q  <= '0;
			aux_q   <= '0;
			ien_q   <= '0;
			flags_q <= '0;
		end else begin
			dir_a_q <= dir_a_n;
			dir_b_q <= dir_b_n;
			out_a_q <= out_a_n;
			out_b_q <= out_b_n;
			in_a_q  <= in_a_n;
			in_b_q  <= in_b_n;
			aux_q   <= aux_n;
			ien_q   <= ien_n;
			flags_q <= flags_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			item_s1 <= in_ch.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= result;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_q;

	`IAT_ASSERT(a_adv_fills_out, advance |=> out_valid_q)
	`IAT_ASSERT(a_irq_matches_state, advance |=> (out_q.irq == |(ien_q & flags_q)))
	`IAT_ASSERT(a_rd_zero_unless_read, (advance && !is_rd) |=> (out_q.read_data == 8'd0))
	`IAT_ASSERT(a_ready_when_empty, !out_valid_q |-> in_ch.ready)

endmodule

// ----- verif/interface_adapter_timers_irq_test.sv -----
// Self-checking testbench for the interface adapter: directed table, then random requests.
`timescale 1ns / 100ps

module interface_adapter_timers_irq_test;

	localparam logic [1:0] CMD_NONE = 2'd3;
	localparam int N_RANDOM = 1125;

	typedef enum logic [1:0] {TMR_IDLE = 2'd0, TMR_LOAD = 2'd1, TMR_RUN = 2'd2} tmr_phase_t;

	typedef struct {
		iat_pkg::in_item_t  rq;
		bit                 typed;
		iat_pkg::out_item_t want;
	} step_row_t;

	logic clk;
	logic arst_n;

	iat_in_if  in_ch();
	iat_out_if out_ch();

	interface_adapter_timers_irq uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// Shadow copy of the adapter registers.
	logic [7:0]  ddr_a, ddr_b, ora, orb, pin_a, pin_b, acr;
	logic [15:0] t1_reload, t1_cnt, t2_reload, t2_cnt;
	logic [6:0]  ier, ifr;
	tmr_phase_t  t1_ph, t2_ph;
	logic        t1_expired;

	iat_pkg::out_item_t pending_outputs[$];
	step_row_t          directed_steps[$];
	int                 mismatches;
	bit                 src_steady;

	function automatic logic irq_level();
		return |(ier & ifr);
	endfunction

	function automatic iat_pkg::out_item_t adapter_step(iat_pkg::in_item_t rq);
		iat_pkg::out_item_t res;
		res = '0;
		if (rq.command == iat_pkg::CMD_TICK) begin
			pin_a = (pin_a & ddr_a) | (rq.port_a_pins & ~ddr_a);
			pin_b = (pin_b & ddr_b) | (rq.port_b_pins & ~ddr_b);
			if (t1_ph == TMR_LOAD) begin
				t1_cnt = t1_reload;
				t1_ph = (t1_expired && !acr[iat_pkg::AUX_T1_FREE]) ? TMR_IDLE : TMR_RUN;
				t1_expired = 1'b0;
			end else begin
				t1_cnt = t1_cnt - 16'd1;
				if (t1_cnt == 16'hffff) begin
					t1_expired = 1'b1;
					if (t1_ph == TMR_RUN)
						ifr[iat_pkg::IRQ_T1_BIT] = 1'b1;
					t1_ph = TMR_LOAD;
				end
			end
			// Timer 2 never reloads on a wrap; it sets its flag when running and changes phase.
			if (t2_ph == TMR_LOAD) begin
				t2_cnt = t2_reload;
				t2_ph = TMR_RUN;
			end else begin
				t2_cnt = t2_cnt - 16'd1;
				if (t2_cnt == 16'hffff) begin
					if (t2_ph == TMR_RUN)
						ifr[iat_pkg::IRQ_T2_BIT] = 1'b1;
					t2_ph = acr[iat_pkg::AUX_T2_PULSE] ? TMR_RUN : TMR_IDLE;
				end
			end
		end else if (rq.command == iat_pkg::CMD_READ && rq.device_select) begin
			case (rq.reg_index)
				iat_pkg::REG_ORB: res.read_data = (orb & ddr_b) | (pin_b & ~ddr_b);
				iat_pkg::REG_ORA, iat_pkg::REG_ORA_NH: res.read_data = pin_a;
				iat_pkg::REG_DDRB: res.read_data = ddr_b;
				iat_pkg::REG_DDRA: res.read_data = ddr_a;
				iat_pkg::REG_T1CL: begin
					if (!rq.no_side_effect)
						ifr[iat_pkg::IRQ_T1_BIT] = 1'b0;
					res.read_data = t1_cnt[7:0];
				end
				iat_pkg::REG_T1CH: res.read_data = t1_cnt[15:8];
				iat_pkg::REG_T1LL: res.read_data = t1_reload[7:0];
				iat_pkg::REG_T1LH: res.read_data = t1_reload[15:8];
				iat_pkg::REG_T2CL: begin
					if (!rq.no_side_effect)
						ifr[iat_pkg::IRQ_T2_BIT] = 1'b0;
					res.read_data = t2_cnt[7:0];
				end
				iat_pkg::REG_T2CH: res.read_data = t2_cnt[15:8];
				iat_pkg::REG_ACR: res.read_data = acr;
				iat_pkg::REG_IFR: res.read_data = {irq_level(), ifr};
				iat_pkg::REG_IER: res.read_data = {1'b1, ier};
				default: res.read_data = 8'h00;
			endcase
		end else if (rq.command == iat_pkg::CMD_WRITE && rq.device_select) begin
			case (rq.reg_index)
				iat_pkg::REG_ORB: orb = rq.write_data;
				iat_pkg::REG_ORA, iat_pkg::REG_ORA_NH: ora = rq.write_data;
				iat_pkg::REG_DDRB: ddr_b = rq.write_data;
				iat_pkg::REG_DDRA: ddr_a = rq.write_data;
				iat_pkg::REG_T1CL, iat_pkg::REG_T1LL: t1_reload[7:0] = rq.write_data;
				iat_pkg::REG_T1CH: begin
					t1_reload[15:8] = rq.write_data;
					ifr[iat_pkg::IRQ_T1_BIT] = 1'b0;
					t1_ph = TMR_LOAD;
					t1_expired = 1'b0;
				end
				iat_pkg::REG_T1LH: begin
					t1_reload[15:8] = rq.write_data;
					ifr[iat_pkg::IRQ_T1_BIT] = 1'b0;
				end
				iat_pkg::REG_T2CL: t2_reload[7:0] = rq.write_data;
				iat_pkg::REG_T2CH: begin
					t2_reload[15:8] = rq.write_data;
					ifr[iat_pkg::IRQ_T2_BIT] = 1'b0;
					t2_ph = TMR_LOAD;
				end
				iat_pkg::REG_ACR: acr = rq.write_data;
				iat_pkg::REG_IFR: ifr = ifr & ~rq.write_data[6:0];
				iat_pkg::REG_IER: begin
					if (rq.write_data[iat_pkg::IER_SET_BIT])
						ier = ier | rq.write_data[6:0];
					else
						ier = ier & ~rq.write_data[6:0];
				end
				default: ;
			endcase
		end
		res.irq = irq_level();
		res.port_a_drive = (ora & ddr_a) | (pin_a & ~ddr_a);
		res.port_b_drive = (orb & ddr_b) | (pin_b & ~ddr_b);
		return res;
	endfunction

	function automatic iat_pkg::in_item_t tick_request(logic [7:0] pa, logic [7:0] pb);
		iat_pkg::in_item_t rq;
		rq = '0;
		rq.command = iat_pkg::CMD_TICK;
		rq.port_a_pins = pa;
		rq.port_b_pins = pb;
		return rq;
	endfunction

	function automatic iat_pkg::in_item_t bus_request(logic [1:0] cmd, logic [3:0] idx,
			logic [7:0] wd, logic sel, logic quiet);
		iat_pkg::in_item_t rq;
		rq = '0;
		rq.command = cmd;
		rq.reg_index = idx;
		rq.write_data = wd;
		rq.device_select = sel;
		rq.no_side_effect = quiet;
		return rq;
	endfunction

	task automatic add_row(iat_pkg::in_item_t rq, bit typed, iat_pkg::out_item_t want);
		step_row_t row;
		row.rq = rq;
		row.typed = typed;
		row.want = want;
		directed_steps.push_back(row);
	endtask

	task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
		$display("%0t: mismatch on %s: got %02h, expected %02h", $realtime, what, got, want);
		mismatches++;
	endtask

	// Entered and left at a falling edge; valid drops only for a random gap before a request.
	task automatic issue_request(iat_pkg::in_item_t rq, bit typed, iat_pkg::out_item_t want);
		int gap;
		iat_pkg::out_item_t predicted;
		if ($urandom_range(0, 39) == 0)
			src_steady = !src_steady;
		gap = src_steady ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= rq;
		do @(posedge clk); while (!in_ch.ready);
		predicted = adapter_step(rq);
		pending_outputs.push_back(typed ? want : predicted);
		@(negedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// Sink side: random back-pressure with occasional stretches of none.
	initial begin
		int gap;
		bit steady;
		steady = 1'b0;
		out_ch.ready <= 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 39) == 0)
				steady = !steady;
			gap = steady ? 0 : $urandom_range(0, 9);
			if (gap > 0) begin
				out_ch.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		iat_pkg::out_item_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_outputs.size() == 0) begin
				report_mismatch("unexpected result", out_ch.data.read_data, 8'h00);
			end else begin
				want = pending_outputs.pop_front();
				if (out_ch.data.read_data !== want.read_data)
					report_mismatch("read_data", out_ch.data.read_data, want.read_data);
				if (out_ch.data.irq !== want.irq)
					report_mismatch("irq", {7'd0, out_ch.data.irq}, {7'd0, want.irq});
				if (out_ch.data.port_a_drive !== want.port_a_drive)
					report_mismatch("port_a_drive", out_ch.data.port_a_drive, want.port_a_drive);
				if (out_ch.data.port_b_drive !== want.port_b_drive)
					report_mismatch("port_b_drive", out_ch.data.port_b_drive, want.port_b_drive);
			end
		end
	end

	initial begin
		iat_pkg::in_item_t rq;
		int pick;
		logic [3:0] timer_regs[6];

		timer_regs = '{iat_pkg::REG_T1CL, iat_pkg::REG_T1CH, iat_pkg::REG_T2CL,
			iat_pkg::REG_T2CH, iat_pkg::REG_IER, iat_pkg::REG_ACR};
		mismatches = 0;
		src_steady = 1'b0;
		{ddr_a, ddr_b, ora, orb, pin_a, pin_b, acr} = '0;
		{t1_reload, t1_cnt, t2_reload, t2_cnt} = '0;
		ier = '0;
		ifr = '0;
		t1_ph = TMR_IDLE;
		t2_ph = TMR_IDLE;
		t1_expired = 1'b0;

		arst_n = 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.data <= '0;

		// Pin extremes, reset values, an unknown command and unselected accesses.
		add_row(tick_request(8'hff, 8'h00), 1'b1, {8'h00, 1'b0, 8'hff, 8'h00});
		add_row(tick_request(8'h00, 8'hff), 1'b1, {8'h00, 1'b0, 8'h00, 8'hff});
		add_row(bus_request(iat_pkg::CMD_READ, iat_pkg::REG_IER, 8'h00, 1'b1, 1'b0), 1'b1,
			{8'h80, 1'b0, 8'h00, 8'hff});
		add_row(bus_request(CMD_NONE, iat_pkg::REG_IER, 8'hff, 1'b1, 1'b0), 1'b1,
			{8'h00, 1'b0, 8'h00, 8'hff});
		add_row(bus_request(iat_pkg::CMD_READ, iat_pkg::REG_T1CL, 8'h00, 1'b0, 1'b0), 1'b1,
			{8'h00, 1'b0, 8'h00, 8'hff});
		add_row(bus_request(iat_pkg::CMD_WRITE, iat_pkg::REG_DDRA, 8'hff, 1'b0, 1'b0), 1'b1,
			{8'h00, 1'b0, 8'h00, 8'hff});
		// Port direction and output registers, then a tick to merge them.
		add_row(bus_request(iat_pkg::CMD_WRITE, iat_pkg::REG_DDRA, 8'hf0, 1'b1, 1'b0), 1'b0, '0);
		add_row(bus_request(iat_pkg::CMD_WRITE, iat_pkg::REG_DDRB, 8'h0f, 1'b1, 1'b0), 1'b0, '0);
		add_row(bus_request(iat_pkg::CMD_WRITE, iat_pkg::REG_ORA, 8'ha5, 1'b1, 1'b0), 1'b0, '0);
		add_row(bus_request(iat_pkg::CMD_WRITE, iat_pkg::REG_ORB, 8'h3c, 1'b1, 1'b0), 1'b0, '0);
		add_row(tick_request(8'h55, 8'haa), 1'b0, '0);
		add_row(bus_request(iat_pkg::CMD_READ, iat_pkg::REG_ORA_NH, 8'h00, 1'b1, 1'b0), 1'b0, '0);
		add_row(bus_request(iat_pkg::CMD_READ, iat_pkg::REG_ORB, 8'h00, 1'b1, 1'b0), 1'b0, '0);
		add_row(bus_request(iat_pkg::CMD_WRITE, iat_pkg::REG_ORA_NH, 8'h5a, 1'b1, 1'b0), 1'b0, '0);
		// Enable all interrupts and arm both timers with short periods.
		add_row(bus_request(iat_pkg::CMD_WRITE, iat_pkg::REG_IER, 8'hff, 1'b1, 1'b0), 1'b0, '0);
		add_row(bus_request(iat_pkg::CMD_WRITE, iat_pkg::REG_T1LL, 8'h01, 1'b1, 1'b0), 1'b0, '0);
		add_row(bus_request(iat_pkg::CMD_WRITE, iat_pkg::REG_T1CH, 8'h00, 1'b1, 1'b0), 1'b0, '0);
		add_row(bus_request(iat_pkg::CMD_WRITE, iat_pkg::REG_T2CL, 8'h00, 1'b1, 1'b0), 1'b0, '0);
		add_row(bus_request(iat_pkg::CMD_WRITE, iat_pkg::REG_T2CH, 8'h00, 1'b1, 1'b0), 1'b0, '0);
		add_row(bus_request(iat_pkg::CMD_WRITE, iat_pkg::REG_ACR, 8'he0, 1'b1, 1'b0), 1'b0, '0);
		add_row(tick_request(8'h00, 8'h00), 1'b0, '0);
		add_row(tick_request(8'hff, 8'hff), 1'b0, '0);
		add_row(bus_request(iat_pkg::CMD_READ, iat_pkg::REG_IFR, 8'h00, 1'b1, 1'b1), 1'b0, '0);
		add_row(bus_request(iat_pkg::CMD_READ, iat_pkg::REG_T1CL, 8'h00, 1'b1, 1'b0), 1'b0, '0);
		add_row(bus_request(iat_pkg::CMD_READ, iat_pkg::REG_T2CL, 8'h00, 1'b1, 1'b0), 1'b0, '0);

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_steps[i])
			issue_request(directed_steps[i].rq, directed_steps[i].typed, directed_steps[i].want);

		for (int n = 0; n < N_RANDOM; n++) begin
			rq.reg_index = 4'($urandom_range(0, 15));
			rq.write_data = 8'($urandom_range(0, 255));
			rq.device_select = ($urandom_range(0, 9) != 0);
			rq.no_side_effect = 1'($urandom_range(0, 1));
			rq.port_a_pins = 8'($urandom_range(0, 255));
			rq.port_b_pins = 8'($urandom_range(0, 255));
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				rq.command = iat_pkg::CMD_TICK;
			end else if (pick < 70) begin
				rq.command = iat_pkg::CMD_READ;
			end else if (pick < 95) begin
				rq.command = iat_pkg::CMD_WRITE;
				if ($urandom_range(0, 2) == 0)
					rq.reg_index = timer_regs[3'($urandom_range(0, 5))];
				// Keep most timer periods short so that wraps and flags show up often.
				case (rq.reg_index)
					iat_pkg::REG_T1CH, iat_pkg::REG_T1LH, iat_pkg::REG_T2CH:
						if ($urandom_range(0, 4) != 0)
							rq.write_data = 8'h00;
					iat_pkg::REG_T1CL, iat_pkg::REG_T1LL, iat_pkg::REG_T2CL:
						if ($urandom_range(0, 4) != 0)
							rq.write_data = 8'($urandom_range(0, 12));
					default: ;
				endcase
			end else if (pick < 98) begin
				rq.command = $urandom_range(0, 1) ? iat_pkg::CMD_READ : iat_pkg::CMD_WRITE;
				rq.device_select = 1'b0;
			end else begin
				rq.command = CMD_NONE;
			end
			issue_request(rq, 1'b0, '0);
		end

		in_ch.valid <= 1'b0;
		while (pending_outputs.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/iat_pkg.sv
rtl/iat_if.sv
rtl/iat_timers.sv
rtl/interface_adapter_timers_irq.sv
verif/interface_adapter_timers_irq_test.sv
